// ----- hw/rtl/arpc_pkg.sv -----
// arpc_pkg: shared sizes, operation codes and payload types for the ARP cache table.
// Depends on nothing; every other file in hw/rtl depends on it.
package arpc_pkg;

   localparam int ENTRIES = 16;
   localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int IP_W    = 32;
   localparam int MAC_W   = 48;
   localparam int PORT_W  = 8;

   // Operation codes; any other code is handled as a lookup.
   localparam logic [1:0] MODE_ADD    = 2'd1;
   localparam logic [1:0] MODE_DELETE = 2'd2;

   typedef struct packed {
      logic [1:0]        mode;
      logic [IP_W-1:0]   ip_key;
      logic [MAC_W-1:0]  mac_in;
      logic [PORT_W-1:0] port_in;
   } req_type;

   typedef struct packed {
      logic              hit;
      logic [MAC_W-1:0]  mac_out;
      logic [PORT_W-1:0] port_out;
      logic              changed;
      logic              full_res;
   } rsp_type;

   typedef logic [ENTRIES-1:0][IP_W-1:0] ip_table_type;

   // Result of the parallel key compare and free-slot search.
   typedef struct packed {
      logic             hit;
      logic [IDX_W-1:0] hit_idx;
      logic             free;
      logic [IDX_W-1:0] free_idx;
   } match_type;

   // One word of the entry data memory.
   typedef struct packed {
      logic [MAC_W-1:0]  mac;
      logic [PORT_W-1:0] port;
   } entry_type;

endpackage

// ----- hw/rtl/arpc_chan_if.sv -----
// arpc_req_if / arpc_rsp_if: valid/ready channels carrying requests and responses.
// Depends on arpc_pkg for the payload types.
interface arpc_req_if;
   logic              valid;
   logic              ready;
   arpc_pkg::req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface arpc_rsp_if;
   logic              valid;
   logic              ready;
   arpc_pkg::rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ----- hw/rtl/arpc_match.sv -----
// arpc_match: parallel key compare over all slots plus lowest-free-slot search.
// Depends on arpc_pkg.
module arpc_match (
   input  arpc_pkg::ip_table_type            ip_tab_i,
   input  logic [arpc_pkg::ENTRIES-1:0]      valid_i,
   input  logic [arpc_pkg::IP_W-1:0]         key_i,
   output arpc_pkg::match_type               match_o
);
   import arpc_pkg::*;

   // Walk from the top down so the lowest-numbered slot wins.
   always_comb begin
      match_o = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (valid_i[i] && (ip_tab_i[i] == key_i)) begin
            match_o.hit     = 1'b1;
            match_o.hit_idx = IDX_W'(i);
         end
         if (!valid_i[i]) begin
            match_o.free     = 1'b1;
            match_o.free_idx = IDX_W'(i);
         end
      end
   end

endmodule

// ----- hw/rtl/arp_cache_table_unit.sv -----
// arp_cache_table_unit: ARP cache of ENTRIES slots keyed on IPv4 address.
// Depends on arpc_pkg, arpc_req_if / arpc_rsp_if and arpc_match.
//
// Usage:
//  - req_chan carries one request: mode (lookup, add/replace, delete), key,
//    and the MAC / interface index to store on add. Mode 3 acts as lookup.
//  - rsp_chan returns exactly one response per request: hit plus the stored
//    MAC / port as they were before the update (zero on miss), changed, and
//    full_res when an add of a new key finds no free slot.
//  - Timing: a request is taken in IDLE, keys are compared in parallel in
//    CMP while the entry data memory is read, and the response is formed
//    and the table written in RD; rsp valid comes from the output register
//    loaded when RD completes. A new request is taken only after the last
//    one leaves RD, since the entry data memory is read in CMP and written
//    back in RD; only one request is in flight, so a read never meets a
//    pending write to the same slot.
//  - The response sits in an output register; the next request is accepted
//    while it waits. If rsp_ready stays low, the following request holds
//    in RD until the register frees up, so nothing is dropped.
//  - Reset (synchronous) clears all valid bits and the channel state at
//    once; no clearing pass. Keys and entry data are undefined until written.
module arp_cache_table_unit (
   input  logic       clock,
   input  logic       reset,
   arpc_req_if.sink   req_chan,
   arpc_rsp_if.source rsp_chan
);
   import arpc_pkg::*;

   typedef enum logic [1:0] {S_IDLE, S_CMP, S_RD} state_type;

   state_type            state_ff, state_in;
   req_type              op_ff;
   match_type            match;
   match_type            mt_ff;
   ip_table_type         ip_tab_ff;
   logic [ENTRIES-1:0]   valid_ff, valid_in;
   entry_type            mem [ENTRIES];
   entry_type            rd_data_ff;
   rsp_type              rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 req_ready;
   logic                 done;
   logic                 same_data;
   logic                 wr_en;
   logic                 ins_key;
   logic [IDX_W-1:0]     wr_idx;

   assign req_ready      = (state_ff == S_IDLE);
   assign req_chan.ready = req_ready;
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;

   // Keys live in flops so all slots compare at once.
   arpc_match u_match (
      .ip_tab_i (ip_tab_ff),
      .valid_i  (valid_ff),
      .key_i    (op_ff.ip_key),
      .match_o  (match)
   );

   // RD completes only when the output register can take the response.
   assign done      = (state_ff == S_RD) && (!rsp_valid_ff || rsp_chan.ready);
   assign same_data = (rd_data_ff.mac == op_ff.mac_in) && (rd_data_ff.port == op_ff.port_in);

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_in       = rsp_ff;
      valid_in     = valid_ff;
      wr_en        = 1'b0;
      ins_key      = 1'b0;
      wr_idx       = mt_ff.hit_idx;
      case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            state_in = S_RD;
         end
         S_RD: begin
            if (done) begin
               state_in         = S_IDLE;
               rsp_valid_in     = 1'b1;
               rsp_in.hit       = mt_ff.hit;
               rsp_in.mac_out   = mt_ff.hit ? rd_data_ff.mac : '0;
               rsp_in.port_out  = mt_ff.hit ? rd_data_ff.port : '0;
               rsp_in.changed   = 1'b0;
               rsp_in.full_res  = 1'b0;
               case (op_ff.mode)
                  MODE_ADD: begin
                     if (mt_ff.hit) begin
                        // existing key: rewrite only if data differs
                        if (!same_data) begin
                           wr_en          = 1'b1;
                           rsp_in.changed = 1'b1;
                        end
                     end else if (mt_ff.free) begin
                        wr_en                    = 1'b1;
                        ins_key                  = 1'b1;
                        wr_idx                   = mt_ff.free_idx;
                        valid_in[mt_ff.free_idx] = 1'b1;
                        rsp_in.changed           = 1'b1;
                     end else begin
                        rsp_in.full_res = 1'b1;
                     end
                  end
                  MODE_DELETE: begin
                     if (mt_ff.hit) begin
                        valid_in[mt_ff.hit_idx] = 1'b0;
                        rsp_in.changed          = 1'b1;
                     end
                  end
                  default: begin
                     // lookup: no table update
                  end
               endcase
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state and registered response.
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         valid_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         valid_ff     <= valid_in;
      end
   end

   // Request capture, compare result and key table.
   always_ff @(posedge clock) begin
      if (req_chan.valid && req_ready) begin
         op_ff <= req_chan.payload;
      end
      if (state_ff == S_CMP) begin
         mt_ff <= match;
      end
      if (ins_key) begin
         ip_tab_ff[wr_idx] <= op_ff.ip_key;
      end
   end

   // Entry data memory: read in CMP at the matched slot, written in RD.
   always_ff @(posedge clock) begin
      if (state_ff == S_CMP) begin
         rd_data_ff <= mem[match.hit_idx];
      end
      if (wr_en) begin
         mem[wr_idx] <= '{mac: op_ff.mac_in, port: op_ff.port_in};
      end
   end

`ifndef SYNTH
   a_full_only_on_miss: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.full_res) |-> (!rsp_ff.hit && !rsp_ff.changed))
      else $error("full_res reported together with hit or changed");

   a_miss_zero_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.hit) |-> ((rsp_ff.mac_out == '0) && (rsp_ff.port_out == '0)))
      else $error("miss response carries nonzero data");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      (done && ins_key) |=> ($countones(valid_ff) == $past($countones(valid_ff)) + 1))
      else $error("insert did not add exactly one valid slot");

   a_delete_shrinks: assert property (@(posedge clock) disable iff (reset)
      (done && (op_ff.mode == MODE_DELETE) && mt_ff.hit)
      |=> ($countones(valid_ff) + 1 == $past($countones(valid_ff))))
      else $error("delete did not remove exactly one valid slot");

   a_no_mem_write_outside_rd: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> done)
      else $error("entry memory written outside response completion");
`endif

endmodule

// ----- test/arp_cache_table_unit_tb.sv -----
// arp_cache_table_unit_tb: self-checking bench for the ARP cache table (lookup / add / delete).
// Depends on arpc_pkg and arpc_req_if / arpc_rsp_if; drives one request channel and
// scores every response against a cycle-free table model kept in the bench.
module arp_cache_table_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import arpc_pkg::*;

   // The package names add and delete only; every other code is a lookup.
   localparam logic [1:0] MODE_LOOKUP = 2'd0;
   localparam logic [1:0] MODE_SPARE  = 2'd3;

   localparam int POOL_KEYS = 24;   // more keys than slots, so the table fills up
   localparam int PHASE_REQS = 138;
   localparam int DRAIN_CYCLES = 8;

   logic clock = 1'b0;
   logic reset = 1'b1;

   arpc_req_if req_chan ();
   arpc_rsp_if rsp_chan ();

   arp_cache_table_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   // Directed request row; the wanted response is typed in only where obvious.
   typedef struct {
      req_type req;
      bit      typed;
      rsp_type want;
   } stim_row_type;

   // Bench copy of the cache contents.
   bit                cache_valid [ENTRIES];
   logic [IP_W-1:0]   cache_ip    [ENTRIES];
   logic [MAC_W-1:0]  cache_mac   [ENTRIES];
   logic [PORT_W-1:0] cache_port  [ENTRIES];

   rsp_type      pending_rsp [$];   // responses owed by the DUT, oldest first
   stim_row_type stim_rows   [$];
   logic [IP_W-1:0] key_pool [POOL_KEYS];

   int mismatches   = 0;
   int tx_idle_pct  = 0;
   int rx_stall_pct = 0;

   initial begin
      forever #6 clock = ~clock;
   end

   // Hard stop well past the slowest legal run (~580 requests, heavy stalls).
   initial begin
      #2_000_000;
      $display("status: fail");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Table model
   // ---------------------------------------------------------------------

   // Lowest valid slot holding the key, or -1.
   function automatic int find_key_slot(logic [IP_W-1:0] key);
      for (int i = 0; i < ENTRIES; i++) begin
         if (cache_valid[i] && cache_ip[i] == key) return i;
      end
      return -1;
   endfunction

   // Lowest free slot, or -1 when the table is full.
   function automatic int find_free_slot();
      for (int i = 0; i < ENTRIES; i++) begin
         if (!cache_valid[i]) return i;
      end
      return -1;
   endfunction

   // Response for one request; applies the add / delete to the model.
   // Reported MAC / port are the ones found before the update.
   function automatic rsp_type resolve_arp(req_type r);
      rsp_type res;
      int      idx;
      int      fr;
      res = '0;
      idx = find_key_slot(r.ip_key);
      if (idx >= 0) begin
         res.hit      = 1'b1;
         res.mac_out  = cache_mac[idx];
         res.port_out = cache_port[idx];
      end
      case (r.mode)
         MODE_ADD: begin
            if (idx >= 0) begin
               // same data: leave it alone, changed stays low
               if (cache_mac[idx] != r.mac_in || cache_port[idx] != r.port_in) begin
                  cache_mac[idx]  = r.mac_in;
                  cache_port[idx] = r.port_in;
                  res.changed     = 1'b1;
               end
            end else begin
               fr = find_free_slot();
               if (fr >= 0) begin
                  cache_valid[fr] = 1'b1;
                  cache_ip[fr]    = r.ip_key;
                  cache_mac[fr]   = r.mac_in;
                  cache_port[fr]  = r.port_in;
                  res.changed     = 1'b1;
               end else begin
                  res.full_res = 1'b1;   // new key, no room
               end
            end
         end
         MODE_DELETE: begin
            if (idx >= 0) begin
               cache_valid[idx] = 1'b0;
               res.changed      = 1'b1;
            end
         end
         default: ;   // lookup and the spare code change nothing
      endcase
      return res;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   function automatic rsp_type make_rsp(logic hit, logic [MAC_W-1:0] mac,
                                        logic [PORT_W-1:0] port, logic changed,
                                        logic full);
      rsp_type r;
      r.hit      = hit;
      r.mac_out  = mac;
      r.port_out = port;
      r.changed  = changed;
      r.full_res = full;
      return r;
   endfunction

   task automatic push_row(logic [1:0] mode, logic [IP_W-1:0] key, logic [MAC_W-1:0] mac,
                           logic [PORT_W-1:0] port, bit typed, rsp_type want);
      stim_row_type row;
      row.req.mode    = mode;
      row.req.ip_key  = key;
      row.req.mac_in  = mac;
      row.req.port_in = port;
      row.typed       = typed;
      row.want        = want;
      stim_rows.push_back(row);
   endtask

   // Present one request, hold it until taken, then book its response.
   // Called at a rising edge; valid is only lowered inside the idle loop, so it
   // never gets two assignments in one step.
   task automatic send_request(req_type r, bit typed, rsp_type want);
      rsp_type pred;
      while ($urandom_range(99) < tx_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.payload <= r;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      pred = resolve_arp(r);
      pending_rsp.push_back(typed ? want : pred);
   endtask

   // Mostly pool keys so adds, hits and deletes meet; some fresh keys for misses.
   task automatic make_random_request(int add_wt, output req_type r);
      int idx;
      int pick;
      r.ip_key  = ($urandom_range(99) < 85) ? key_pool[$urandom_range(POOL_KEYS - 1)]
                                            : $urandom;
      r.mac_in  = 48'({$urandom, $urandom});
      r.port_in = 8'($urandom_range(255));
      pick = $urandom_range(99);
      if (pick < add_wt)            r.mode = MODE_ADD;
      else if (pick < add_wt + 25)  r.mode = MODE_DELETE;
      else if (pick < add_wt + 30)  r.mode = MODE_SPARE;
      else                          r.mode = MODE_LOOKUP;
      idx = find_key_slot(r.ip_key);
      if (r.mode == MODE_ADD && idx >= 0) begin
         // steer some adds to hit the same-data and port-only / MAC-only cases
         case ($urandom_range(3))
            0: begin
               r.mac_in  = cache_mac[idx];
               r.port_in = cache_port[idx];
            end
            1: r.mac_in  = cache_mac[idx];
            2: r.port_in = cache_port[idx];
            default: ;
         endcase
      end
   endtask

   // ---------------------------------------------------------------------
   // Response side: random backpressure and scoring
   // ---------------------------------------------------------------------

   initial begin
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_chan.ready <= ($urandom_range(99) >= rx_stall_pct);
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      rsp_type got;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got = rsp_chan.payload;
         if (pending_rsp.size() == 0) begin
            $error("response with no request outstanding: %h", got);
            mismatches++;
         end else begin
            want = pending_rsp.pop_front();
            if (got.hit !== want.hit) begin
               $error("hit: expected %0h, actual %0h", want.hit, got.hit);
               mismatches++;
            end
            if (got.mac_out !== want.mac_out) begin
               $error("mac_out: expected %h, actual %h", want.mac_out, got.mac_out);
               mismatches++;
            end
            if (got.port_out !== want.port_out) begin
               $error("port_out: expected %h, actual %h", want.port_out, got.port_out);
               mismatches++;
            end
            if (got.changed !== want.changed) begin
               $error("changed: expected %0h, actual %0h", want.changed, got.changed);
               mismatches++;
            end
            if (got.full_res !== want.full_res) begin
               $error("full_res: expected %0h, actual %0h", want.full_res, got.full_res);
               mismatches++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------

   initial begin
      req_type r;
      rsp_type none;
      none = '0;

      req_chan.valid   <= 1'b0;
      req_chan.payload <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
         cache_valid[i] = 1'b0;
         cache_ip[i]    = '0;
         cache_mac[i]   = '0;
         cache_port[i]  = '0;
      end
      key_pool[0] = '0;
      key_pool[1] = '1;
      for (int i = 2; i < POOL_KEYS; i++) key_pool[i] = $urandom;

      // Directed rows. Empty table first, then key / data extremes, then fill it.
      push_row(MODE_LOOKUP, 32'h0, '0, '0, 1'b1, none);               // miss after reset
      push_row(MODE_DELETE, '1, '0, '0, 1'b1, none);                  // delete, key absent
      push_row(MODE_ADD, 32'h0, '0, '0, 1'b1,
               make_rsp(1'b0, '0, '0, 1'b1, 1'b0));                   // new key, all-zero data
      push_row(MODE_ADD, 32'h0, '0, '0, 1'b1,
               make_rsp(1'b1, '0, '0, 1'b0, 1'b0));                   // same data, no write
      push_row(MODE_ADD, '1, '1, '1, 1'b1,
               make_rsp(1'b0, '0, '0, 1'b1, 1'b0));                   // new key, all-one data
      push_row(MODE_ADD, '1, '1, '0, 1'b1,
               make_rsp(1'b1, '1, '1, 1'b1, 1'b0));                   // other data, replace
      push_row(MODE_SPARE, '1, '1, '1, 1'b0, none);                   // spare code = lookup
      push_row(MODE_DELETE, 32'h0, '1, '1, 1'b0, none);               // delete hit frees slot 0
      // one slot is held, so ENTRIES-1 new keys fill the table
      for (int i = 0; i < ENTRIES - 1; i++) begin
         push_row(MODE_ADD, 32'h0A00_0000 + i, {16'hA5C3, 32'(i * 32'h0101_0101)},
                  8'(8'h11 * i), 1'b0, none);
      end
      push_row(MODE_ADD, 32'hC0A8_0001, '1, '1, 1'b1,
               make_rsp(1'b0, '0, '0, 1'b0, 1'b1));                   // refused, full
      push_row(MODE_ADD, '1, 48'h0123_4567_89AB, 8'h5A, 1'b0, none);  // replace while full

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (stim_rows[i]) send_request(stim_rows[i].req, stim_rows[i].typed, stim_rows[i].want);

      // Random phases: no idling, sender idle, receiver stall, both.
      // Add-heavy phases keep the table near full; the others weigh adds and deletes evenly.
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
            1: begin tx_idle_pct = 45; rx_stall_pct = 0;  end
            2: begin tx_idle_pct = 0;  rx_stall_pct = 45; end
            default: begin tx_idle_pct = 17; rx_stall_pct = 17; end
         endcase
         for (int n = 0; n < PHASE_REQS; n++) begin
            make_random_request((phase % 2 == 0) ? 45 : 25, r);
            send_request(r, 1'b0, none);
         end
      end
      req_chan.valid <= 1'b0;

      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
hw/rtl/arpc_pkg.sv
hw/rtl/arpc_chan_if.sv
hw/rtl/arpc_match.sv
hw/rtl/arp_cache_table_unit.sv
test/arp_cache_table_unit_tb.sv
